/* hdl/rpn_pkg.sv */
`default_nettype none
package rpn_pkg;

  localparam int unsigned DefStackDepth = 128;
  localparam int unsigned ValueW = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CharW = 8;

  localparam logic [CharW-1:0] ChPlus  = 8'h2B;
  localparam logic [CharW-1:0] ChMinus = 8'h2D;
  localparam logic [CharW-1:0] ChMul   = 8'h2A;
  localparam logic [CharW-1:0] ChDiv   = 8'h2F;
  localparam logic [CharW-1:0] ChDot   = 8'h2E;
  localparam logic [CharW-1:0] ChZero  = 8'h30;

  localparam logic [StatusW-1:0] StOk    = 2'd0;
  localparam logic [StatusW-1:0] StUnder = 2'd1;
  localparam logic [StatusW-1:0] StOver  = 2'd2;
  localparam logic [StatusW-1:0] StDivz  = 2'd3;

  typedef enum logic [1:0] {
    OpAdd,
    OpSub,
    OpMul,
    OpDiv
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ_A,
    S_READ_B,
    S_WAIT,
    S_MUL,
    S_DIV,
    S_WRITE,
    S_EOL_READ,
    S_EOL_WAIT,
    S_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic       load_in;    // capture char
    logic       set_res_sum; // result value = saturated sum / difference
    logic       rd_next;    // read address count-2
    logic       cap_a;      // rd data -> a
    logic       cap_b;      // rd data -> b
    logic       push;       // write pushed digit at count, count++
    logic       mul_start;
    logic       div_start;
    logic       wr_res;     // write result at count-2, count--
    logic       set_res_a;  // result value = rd data (top of stack)
    logic       set_res_zero;
    logic       clr_count;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       cnt_zero;
    logic       cnt_lt2;
    logic       cnt_full;
    logic       a_zero;
    logic       mul_done;
    logic       div_done;
  } sts_t;

endpackage
`default_nettype wire

/* hdl/rpn_divider.sv */
`default_nettype none
// Signed Q16.16 divide, (b<<16)/a, truncating, saturating. One quotient bit a cycle.
module rpn_divider (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [rpn_pkg::ValueW-1:0] b_i,
  input  wire logic [rpn_pkg::ValueW-1:0] a_i,
  output logic                            done_o,
  output logic [rpn_pkg::ValueW-1:0]      q_o
);
  import rpn_pkg::*;

  localparam int unsigned NumW = 48;
  localparam int unsigned CntW = 6;

  logic [NumW-1:0] num_q, num_d;
  logic [ValueW-1:0] den_q, den_d;
  logic [NumW-1:0] rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, neg_q, neg_d, done_q, done_d;
  logic [ValueW-1:0] q_q, q_d;
  logic [NumW:0] shifted;
  logic [NumW:0] diff;
  logic [ValueW-1:0] bmag, amag;

  always_comb begin
    bmag = b_i[ValueW-1] ? (~b_i + 1'b1) : b_i;
    amag = a_i[ValueW-1] ? (~a_i + 1'b1) : a_i;
    shifted = {rem_q, num_q[NumW-1]};
    diff = shifted - {{(NumW+1-ValueW){1'b0}}, den_q};
    num_d = num_q;
    den_d = den_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    neg_d = neg_q;
    done_d = 1'b0;
    q_d = q_q;
    if (start_i) begin
      num_d = {bmag, 16'h0000};
      den_d = amag;
      rem_d = '0;
      cnt_d = CntW'(NumW - 1);
      busy_d = 1'b1;
      neg_d = b_i[ValueW-1] ^ a_i[ValueW-1];
    end else if (busy_q) begin
      if (!diff[NumW]) begin
        rem_d = diff[NumW-1:0];
        num_d = {num_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = shifted[NumW-1:0];
        num_d = {num_q[NumW-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        // num_d now holds the magnitude of the quotient
        if (neg_q) begin
          if (num_d > NumW'(33'h80000000)) q_d = 32'h80000000;
          else q_d = ValueW'(~num_d + 1'b1);
        end else begin
          if (num_d > NumW'(32'h7FFFFFFF)) q_d = 32'h7FFFFFFF;
          else q_d = num_d[ValueW-1:0];
        end
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
    q_q   <= q_d;
  end

  assign done_o = done_q;
  assign q_o = q_q;

endmodule
`default_nettype wire

/* hdl/rpn_datapath.sv */
`default_nettype none
module rpn_datapath #(
  parameter int unsigned StackDepth = rpn_pkg::DefStackDepth
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire rpn_pkg::cmd_t               cmd_i,
  input  wire logic [rpn_pkg::CharW-1:0]   ch_i,
  output rpn_pkg::sts_t                    sts_o,
  output logic [rpn_pkg::ValueW-1:0]       value_o
);
  import rpn_pkg::*;

  localparam int unsigned AddrW = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int unsigned CntW = $clog2(StackDepth + 1);

  logic [ValueW-1:0] mem [StackDepth];
  logic [ValueW-1:0] rd_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CharW-1:0] ch_q;
  logic [ValueW-1:0] a_q, b_q, res_q, res_d, mul_q;
  logic signed [2*ValueW-1:0] prod_q;
  logic mul_ph_q, mul_done_q;
  logic [ValueW-1:0] div_q;
  logic div_done;
  logic [CntW-1:0] rd_addr_full;
  logic [AddrW-1:0] rd_addr;
  logic [ValueW:0] sum_w;
  logic [ValueW-1:0] sum_sat;
  logic signed [2*ValueW-1:0] shq;

  always_comb begin
    if (cmd_i.rd_next) rd_addr_full = cnt_q - CntW'(2);
    else rd_addr_full = cnt_q - CntW'(1);
    rd_addr = rd_addr_full[AddrW-1:0];
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[rd_addr];
    if (cmd_i.push) begin
      // code minus '0' wraps in 16 bits before the shift
      mem[cnt_q[AddrW-1:0]] <= {16'({8'h00, ch_q} - {8'h00, ChZero}), 16'h0000};
    end else if (cmd_i.wr_res) begin
      mem[AddrW'(cnt_q - CntW'(2))] <= res_q;
    end
  end

  // add / subtract with saturation
  always_comb begin
    if (ch_q == ChMinus)
      sum_w = {b_q[ValueW-1], b_q} - {a_q[ValueW-1], a_q};
    else
      sum_w = {b_q[ValueW-1], b_q} + {a_q[ValueW-1], a_q};
    if (sum_w[ValueW] != sum_w[ValueW-1])
      sum_sat = sum_w[ValueW] ? 32'h80000000 : 32'h7FFFFFFF;
    else
      sum_sat = sum_w[ValueW-1:0];
    // truncate toward zero when shifting by 16
    shq = (prod_q + ((prod_q < 0) ? 64'sd65535 : 64'sd0)) >>> 16;
  end

  rpn_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .b_i     (b_q),
    .a_i     (a_q),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.clr_count) cnt_d = '0;
    else if (cmd_i.push) cnt_d = cnt_q + 1'b1;
    else if (cmd_i.wr_res) cnt_d = cnt_q - 1'b1;
    res_d = res_q;
    if (cmd_i.set_res_zero) res_d = '0;
    else if (cmd_i.set_res_a) res_d = rd_q;
    else if (div_done) res_d = div_q;
    else if (mul_done_q) res_d = mul_q;
    else if (cmd_i.set_res_sum) res_d = sum_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      mul_ph_q <= 1'b0;
      mul_done_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      mul_ph_q <= cmd_i.mul_start;
      mul_done_q <= mul_ph_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) ch_q <= ch_i;
    if (cmd_i.cap_a) a_q <= rd_q;
    if (cmd_i.cap_b) b_q <= rd_q;
    res_q <= res_d;
    prod_q <= $signed(b_q) * $signed(a_q);
    if (shq > 64'sh7FFFFFFF) mul_q <= 32'h7FFFFFFF;
    else if (shq < -64'sh80000000) mul_q <= 32'h80000000;
    else mul_q <= shq[ValueW-1:0];
  end

  assign sts_o.cnt_zero = (cnt_q == '0);
  assign sts_o.cnt_lt2 = (cnt_q < CntW'(2));
  assign sts_o.cnt_full = (cnt_q >= CntW'(StackDepth));
  assign sts_o.a_zero = (a_q == '0);
  assign sts_o.mul_done = mul_done_q;
  assign sts_o.div_done = div_done;
  assign value_o = res_q;

endmodule
`default_nettype wire

/* hdl/rpn_ctrl.sv */
`default_nettype none
module rpn_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [rpn_pkg::CharW-1:0]  ch_i,
  input  wire logic                       end_of_line_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [rpn_pkg::StatusW-1:0]     status_o,
  output logic                            final_result_o,
  output rpn_pkg::cmd_t                   cmd_o,
  input  wire rpn_pkg::sts_t              sts_i
);
  import rpn_pkg::*;

  state_e state_q, state_d;
  logic [CharW-1:0] ch_q;
  logic eol_q;
  logic [StatusW-1:0] st_q, st_d;
  logic fin_q, fin_d;
  logic is_op;
  logic [1:0] wait_q, wait_d;

  assign is_op = ch_q inside {ChPlus, ChMinus, ChMul, ChDiv};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q <= StOk;
      fin_q <= 1'b0;
      wait_q <= '0;
    end else begin
      state_q <= state_d;
      st_q <= st_d;
      fin_q <= fin_d;
      wait_q <= wait_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      ch_q <= ch_i;
      eol_q <= end_of_line_i;
    end
  end

  always_comb begin
    state_d = state_q;
    st_d = st_q;
    fin_d = fin_q;
    wait_d = wait_q;
    cmd_o = '0;
    in_stall_o = (state_q != S_IDLE);
    out_valid_o = (state_q == S_OUT);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          st_d = StOk;
          state_d = S_READ_A;
        end
      end
      S_READ_A: begin
        // classify; read port addresses top
        fin_d = eol_q;
        if (is_op) begin
          if (sts_i.cnt_lt2) begin
            st_d = StUnder;
            state_d = eol_q ? S_EOL_READ : S_OUT;
            cmd_o.set_res_zero = 1'b1;
          end else begin
            state_d = S_READ_B;
          end
        end else if (ch_q == ChDot) begin
          if (sts_i.cnt_zero) begin
            st_d = StUnder;
            cmd_o.set_res_zero = 1'b1;
            state_d = eol_q ? S_EOL_READ : S_OUT;
          end else begin
            state_d = S_EOL_READ;
          end
        end else begin
          if (sts_i.cnt_full) begin
            st_d = StOver;
            cmd_o.set_res_zero = 1'b1;
            state_d = eol_q ? S_EOL_READ : S_OUT;
          end else begin
            cmd_o.push = 1'b1;
            state_d = eol_q ? S_EOL_READ : S_IDLE;
          end
        end
      end
      S_READ_B: begin
        // rd data = top now; next read count-2
        cmd_o.cap_a = 1'b1;
        cmd_o.rd_next = 1'b1;
        state_d = S_WAIT;
      end
      S_WAIT: begin
        cmd_o.cap_b = 1'b1;
        if (ch_q == ChDiv) begin
          if (sts_i.a_zero) begin
            st_d = StDivz;
            cmd_o.set_res_zero = 1'b1;
            state_d = eol_q ? S_EOL_READ : S_OUT;
          end else begin
            state_d = S_DIV;
            wait_d = 2'd0;
          end
        end else if (ch_q == ChMul) begin
          state_d = S_MUL;
          wait_d = 2'd0;
        end else begin
          state_d = S_MUL;
          wait_d = 2'd3;
        end
      end
      S_MUL: begin
        // sum: recompute with b captured; multiply: wait for product pipeline
        if (wait_q == 2'd3) begin
          cmd_o.set_res_sum = 1'b1;
          state_d = S_WRITE;
        end else if (wait_q == 2'd0) begin
          cmd_o.mul_start = 1'b1;
          wait_d = 2'd1;
        end else if (sts_i.mul_done) begin
          state_d = S_WRITE;
        end
      end
      S_DIV: begin
        if (wait_q != 2'd2) begin
          cmd_o.div_start = 1'b1;
          wait_d = 2'd2;
        end else if (sts_i.div_done) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.wr_res = 1'b1;
        state_d = eol_q ? S_EOL_READ : S_IDLE;
      end
      S_EOL_READ: begin
        state_d = S_EOL_WAIT;
      end
      S_EOL_WAIT: begin
        cmd_o.cap_a = 1'b1;
        state_d = S_OUT;
        if (eol_q) begin
          if (st_q == StOk && sts_i.cnt_zero) st_d = StUnder;
          cmd_o.clr_count = 1'b1;
        end
      end
      S_OUT: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    // result value: top of stack from rd data in S_EOL_WAIT, also on fault
    if (state_q == S_EOL_WAIT) begin
      cmd_o.set_res_a = 1'b1;
    end
  end

  assign status_o = st_q;
  assign final_result_o = fin_q;

  ap_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o) else $error("input not stalled while busy");
  ap_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(status_o)))
    else $error("result dropped");
  ap_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && !in_stall_o)) else $error("accepting while showing result");

endmodule
`default_nettype wire

/* hdl/rpn_stack_calculator.sv */
`default_nettype none
// Channel | valid      | stall      | payload
// in      | in_valid_i | in_stall_o | ch_i, end_of_line_i
// out     | out_valid_o| out_stall_i| value_o, status_o, final_result_o
// Division uses the bit-serial divider (48 quotient steps). One
// character at a time; the stack memory has one read port and one
// write port, with registered read. Reset clears the stack count and
// control registers, not the stack memory. A stalled result holds the
// block.
module rpn_stack_calculator #(
  parameter int unsigned StackDepth = rpn_pkg::DefStackDepth
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [rpn_pkg::CharW-1:0]   ch_i,
  input  wire logic                        end_of_line_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic signed [rpn_pkg::ValueW-1:0] value_o,
  output logic [rpn_pkg::StatusW-1:0]      status_o,
  output logic                             final_result_o
);
  import rpn_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [ValueW-1:0] dp_value;

  rpn_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .ch_i           (ch_i),
    .end_of_line_i  (end_of_line_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .final_result_o (final_result_o),
    .cmd_o          (cmd),
    .sts_i          (sts)
  );

  rpn_datapath #(.StackDepth(StackDepth)) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .ch_i    (ch_i),
    .sts_o   (sts),
    .value_o (dp_value)
  );

  // faults report zero; the top value is in the result register otherwise
  assign value_o = (status_o == StOk) ? $signed(dp_value) : '0;

endmodule
`default_nettype wire
